### rtl/pcrc_pkg.sv
`default_nettype none
package pcrc_pkg;

  localparam int LENGTH_BITS  = 48;
  localparam int OUT_LEN_BITS = 48;
  localparam int CRC_BITS     = 32;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);

  localparam logic [CRC_BITS-1:0]    CRC_POLY = 32'h04C11DB7;
  localparam logic [LENGTH_BITS-1:0] CNT_ONE  = LENGTH_BITS'(1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [CRC_BITS-1:0]     checksum;
    logic [OUT_LEN_BITS-1:0] message_length;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_TAIL,
    BK_OUT
  } back_state_t;

  // MSB-first CRC update with one byte, bitwise over eight steps
  function automatic logic [CRC_BITS-1:0] crc_feed(input logic [CRC_BITS-1:0] crc,
                                                   input logic [7:0] b);
    logic [CRC_BITS-1:0] c;
    c = crc ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      c = c[CRC_BITS-1] ? ({c[CRC_BITS-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_BITS-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [OUT_LEN_BITS-1:0] to_out_len(input logic [LENGTH_BITS-1:0] cnt);
    logic [63:0] w;
    w = 64'(cnt);
    return w[OUT_LEN_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/pcrc_front.sv
`default_nettype none
module pcrc_front (
  input  wire logic              in_push,
  output logic                   in_full,
  input  pcrc_pkg::in_item_t     in_item,
  input  wire logic              q_full,
  output logic                   q_push,
  output pcrc_pkg::in_item_t     q_item
);
  import pcrc_pkg::*;

  // items that carry neither a byte nor an end mark are dropped here
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && (in_item.byte_valid || in_item.last);
  assign q_item  = in_item;

endmodule
`default_nettype wire

### rtl/pcrc_fifo.sv
`default_nettype none
module pcrc_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  pcrc_pkg::in_item_t     push_item,
  output logic                   full,
  input  wire logic              pop,
  output pcrc_pkg::in_item_t     pop_item,
  output logic                   empty
);
  import pcrc_pkg::*;

  in_item_t         entry_r [QDEPTH];
  logic [QAW:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW:0]     rd_ptr_r, rd_ptr_nxt;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[QAW] != rd_ptr_r[QAW]) &&
                 (wr_ptr_r[QAW-1:0] == rd_ptr_r[QAW-1:0]);
  assign pop_item = entry_r[rd_ptr_r[QAW-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r[QAW-1:0]] <= push_item;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("request pushed into full queue");

endmodule
`default_nettype wire

### rtl/pcrc_back.sv
`default_nettype none
module pcrc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  pcrc_pkg::in_item_t     q_item,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output pcrc_pkg::out_item_t    out_item
);
  import pcrc_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [CRC_BITS-1:0]    crc_r, crc_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [LENGTH_BITS-1:0] shift_r, shift_nxt;
  logic                   res_valid_r, res_valid_nxt;
  out_item_t              res_r, res_nxt;
  logic                   slot_free;
  logic                   load_res;

  assign slot_free = !res_valid_r || out_pop;
  assign out_empty = !res_valid_r;
  assign out_item  = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN:  if (!q_empty && q_item.last) state_nxt = BK_TAIL;
      BK_TAIL: if ((shift_r >> 8) == '0) state_nxt = BK_OUT;
      BK_OUT:  if (slot_free) state_nxt = BK_RUN;
      default: state_nxt = BK_RUN;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    load_res = 1'b0;
    unique case (state_r)
      BK_RUN:  q_pop    = !q_empty;
      BK_TAIL: ;
      BK_OUT:  load_res = slot_free;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    crc_nxt       = crc_r;
    count_nxt     = count_r;
    shift_nxt     = shift_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !out_pop;
    if (q_pop) begin
      if (q_item.byte_valid) begin
        crc_nxt   = crc_feed(crc_r, q_item.data_byte);
        count_nxt = count_r + CNT_ONE;
      end
      shift_nxt = count_nxt;
    end
    if (state_r == BK_TAIL) begin
      // length goes in LSB first; a zero count still feeds one zero byte
      crc_nxt   = crc_feed(crc_r, shift_r[7:0]);
      shift_nxt = shift_r >> 8;
    end
    if (load_res) begin
      res_nxt.checksum       = ~crc_r;
      res_nxt.message_length = to_out_len(count_r);
      res_valid_nxt          = 1'b1;
      crc_nxt                = '0;
      count_nxt              = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      crc_r       <= '0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    res_r   <= res_nxt;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |-> (!res_valid_r || out_pop))
    else $error("result overwritten before taken");

  a_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_RUN))
    else $error("queue popped outside run state");

  a_cleared_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |=> (res_valid_r && crc_r == '0 && count_r == '0 && state_r == BK_RUN))
    else $error("state not cleared after result");

endmodule
`default_nettype wire

### rtl/posix_cksum_crc32.sv
`default_nettype none
// POSIX cksum CRC-32 engine.
// Input queue port: raise in_push with in_item while in_full is low; each
// accepted request carries one byte (byte_valid) and/or an end mark (last).
// Requests with neither are dropped. Bytes enter a 4-entry queue and the
// CRC engine takes one from it per cycle while in its run state, so a
// message streams at one byte per cycle up to its end mark.
// On the end mark the engine appends the byte count, LSB first, one byte per
// cycle (1 to ceil(LENGTH_BITS/8) bytes), then in its output state loads the
// result register once it is free. The result (inverted CRC and the byte
// count) shows on out_item while out_empty is low and leaves on out_pop.
// While a result waits, the engine keeps taking bytes up to the next end
// mark and then holds in its output state; the input queue keeps taking
// requests until it fills, then in_full stalls the sender.
// Synchronous active-low reset empties the queue and result register and
// clears the CRC and the count; no clearing pass is needed.
module posix_cksum_crc32 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  pcrc_pkg::in_item_t     in_item,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output pcrc_pkg::out_item_t    out_item
);
  import pcrc_pkg::*;

  logic     q_full;
  logic     q_push;
  in_item_t q_wr_item;
  logic     q_empty;
  logic     q_pop;
  in_item_t q_rd_item;

  pcrc_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  pcrc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_rd_item),
    .empty     (q_empty)
  );

  pcrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
